// File: sv/qcf_pkg.sv
package qcf_pkg;

  localparam int CRD_W    = 24;
  localparam int STY_W    = 16;
  localparam int MD_W     = 18;
  localparam logic [MD_W-1:0] MD_RESET = 18'd45875;
  localparam int FRAC_W   = 16;
  localparam int MAG_W    = 25;
  localparam int EXT_W    = 25;
  localparam int AQ_W     = 17;
  localparam int ROOT_W   = 17;
  localparam int RAD_W    = 2 * ROOT_W;

  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic [STY_W-1:0] style_t;

  typedef struct packed {
    logic   action;
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    style_t fill_a;
    style_t fill_b;
    style_t stroke;
  } seg_in_t;

  typedef struct packed {
    logic             zero;
    logic [MAG_W-1:0] mag;
    logic [EXT_W-1:0] ext;
  } ax_prep_t;

  typedef struct packed {
    logic    zero_x;
    logic    zero_y;
    seg_in_t item;
  } ax_side_t;

  typedef struct packed {
    logic   first;
    logic   last;
    logic   neg_x;
    logic   neg_y;
    coord_t p0_x;
    coord_t p0_y;
    style_t fill_a;
    style_t fill_b;
    style_t stroke;
  } pt_side_t;

  typedef struct packed {
    logic   first;
    logic   last;
    coord_t p0_x;
    coord_t p0_y;
    coord_t end_x;
    coord_t end_y;
    style_t fill_a;
    style_t fill_b;
    style_t stroke;
  } pt_res_t;

endpackage

// File: sv/qcf_divpipe.sv
module qcf_divpipe #(
  parameter int N_W    = 41,
  parameter int D_W    = 26,
  parameter int Q_W    = 17,
  parameter int BPS    = 3,
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [1:0][N_W-1:0]       num_i,
  input  logic [1:0][D_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [1:0][Q_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int R_W = D_W + Q_W;
  localparam int NST = (Q_W + BPS - 1) / BPS;

  logic [1:0][R_W-1:0] rem_s [NST];
  logic [1:0][Q_W-1:0] quo_s [NST];
  logic [1:0][D_W-1:0] den_s [NST];
  logic [SIDE_W-1:0]   side_s [NST];
  logic                vld_s [NST];

  logic [1:0][R_W-1:0] rem_d [NST];
  logic [1:0][Q_W-1:0] quo_d [NST];
  logic [1:0][R_W-1:0] rem_q [NST];
  logic [1:0][Q_W-1:0] quo_q [NST];
  logic [1:0][D_W-1:0] den_q [NST];
  logic [SIDE_W-1:0]   side_q [NST];
  logic                vld_q [NST];

  assign rem_s[0]  = {R_W'(num_i[1]), R_W'(num_i[0])};
  assign quo_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar st = 0; st < NST; st++) begin : g_st
    if (st > 0) begin : g_link
      assign rem_s[st]  = rem_q[st-1];
      assign quo_s[st]  = quo_q[st-1];
      assign den_s[st]  = den_q[st-1];
      assign side_s[st] = side_q[st-1];
      assign vld_s[st]  = vld_q[st-1];
    end

    always_comb begin
      logic [R_W-1:0] sh;
      int idx;
      rem_d[st] = rem_s[st];
      quo_d[st] = quo_s[st];
      for (int l = 0; l < 2; l++) begin
        for (int j = 0; j < BPS; j++) begin
          idx = st * BPS + j;
          if (idx < Q_W) begin
            sh = R_W'(den_s[st][l]) << (Q_W - 1 - idx);
            if (rem_d[st][l] >= sh) begin
              rem_d[st][l] = rem_d[st][l] - sh;
              quo_d[st][l][Q_W-1-idx] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[st] <= 1'b0;
      end else if (en_i) begin
        vld_q[st] <= vld_s[st];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[st]  <= rem_d[st];
        quo_q[st]  <= quo_d[st];
        den_q[st]  <= den_s[st];
        side_q[st] <= side_s[st];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = quo_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// File: sv/qcf_sqrtpipe.sv
module qcf_sqrtpipe #(
  parameter int RT_W   = 17,
  parameter int BPS    = 3,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*RT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [RT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int V_W = 2 * RT_W;
  localparam int NST = (RT_W + BPS - 1) / BPS;

  logic [V_W-1:0]    rem_s [NST];
  logic [V_W-1:0]    res_s [NST];
  logic [SIDE_W-1:0] side_s [NST];
  logic              vld_s [NST];
  logic [V_W-1:0]    rem_d [NST];
  logic [V_W-1:0]    res_d [NST];
  logic [V_W-1:0]    rem_q [NST];
  logic [V_W-1:0]    res_q [NST];
  logic [SIDE_W-1:0] side_q [NST];
  logic              vld_q [NST];

  assign rem_s[0]  = rad_i;
  assign res_s[0]  = '0;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar st = 0; st < NST; st++) begin : g_st
    if (st > 0) begin : g_link
      assign rem_s[st]  = rem_q[st-1];
      assign res_s[st]  = res_q[st-1];
      assign side_s[st] = side_q[st-1];
      assign vld_s[st]  = vld_q[st-1];
    end

    always_comb begin
      logic [V_W:0] trial;
      logic [V_W-1:0] bitv;
      int idx;
      rem_d[st] = rem_s[st];
      res_d[st] = res_s[st];
      for (int j = 0; j < BPS; j++) begin
        idx = st * BPS + j;
        if (idx < RT_W) begin
          bitv  = V_W'(1) << (2 * (RT_W - 1 - idx));
          trial = {1'b0, res_d[st]} + {1'b0, bitv};
          if ({1'b0, rem_d[st]} >= trial) begin
            rem_d[st] = rem_d[st] - trial[V_W-1:0];
            res_d[st] = (res_d[st] >> 1) + bitv;
          end else begin
            res_d[st] = res_d[st] >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[st] <= 1'b0;
      end else if (en_i) begin
        vld_q[st] <= vld_s[st];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[st]  <= rem_d[st];
        res_q[st]  <= res_d[st];
        side_q[st] <= side_s[st];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = res_q[NST-1][RT_W-1:0];
  assign side_o  = side_q[NST-1];

endmodule

// File: sv/qcf_front.sv
module qcf_front #(
  parameter int MAX_STEPS = 8,
  parameter int SW        = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  qcf_pkg::seg_in_t        item_i,
  input  logic [qcf_pkg::MD_W-1:0] md_i,
  output logic                    valid_o,
  output qcf_pkg::seg_in_t        item_o,
  output logic [SW-1:0]           steps_o
);
  import qcf_pkg::*;

  localparam int DN_W = MAG_W + FRAC_W;
  localparam int DD_W = EXT_W + 1;
  localparam int SCW  = MD_W + SW;

  function automatic ax_prep_t axis_prep(coord_t a, coord_t b, coord_t c);
    logic signed [CRD_W:0] mn;
    logic signed [CRD_W:0] mx;
    logic signed [CRD_W+2:0] s;
    logic signed [CRD_W+2:0] m;
    logic signed [CRD_W+2:0] nm;
    ax_prep_t r;
    mn = (CRD_W+1)'(a);
    mx = (CRD_W+1)'(a);
    if ((CRD_W+1)'(b) < mn) mn = (CRD_W+1)'(b);
    if ((CRD_W+1)'(c) < mn) mn = (CRD_W+1)'(c);
    if ((CRD_W+1)'(b) > mx) mx = (CRD_W+1)'(b);
    if ((CRD_W+1)'(c) > mx) mx = (CRD_W+1)'(c);
    r.ext  = EXT_W'(mx - mn);
    r.zero = (r.ext == '0);
    s  = (CRD_W+3)'(a) + ((CRD_W+3)'(b) <<< 1) + (CRD_W+3)'(c);
    m  = (s < 0) ? ((s + 27'sd3) >>> 2) : (s >>> 2);
    nm = (m <<< 1) - (CRD_W+3)'(a) - (CRD_W+3)'(b);
    r.mag = (nm < 0) ? MAG_W'(-nm) : MAG_W'(nm);
    return r;
  endfunction

  ax_prep_t ax_x_q, ax_y_q;
  seg_in_t  a_item_q;
  logic     a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_x_q   <= axis_prep(item_i.p0_x, item_i.p1_x, item_i.p2_x);
      ax_y_q   <= axis_prep(item_i.p0_y, item_i.p1_y, item_i.p2_y);
      a_item_q <= item_i;
    end
  end

  ax_side_t                div_side_in, div_side;
  logic [1:0][AQ_W-1:0]    quo;
  logic                    div_vld;

  assign div_side_in = '{zero_x: ax_x_q.zero, zero_y: ax_y_q.zero, item: a_item_q};

  qcf_divpipe #(
    .N_W(DN_W), .D_W(DD_W), .Q_W(AQ_W), .BPS(3), .SIDE_W($bits(ax_side_t))
  ) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (a_vld_q),
    .num_i   ({{ax_y_q.mag, FRAC_W'(0)}, {ax_x_q.mag, FRAC_W'(0)}}),
    .den_i   ({{ax_y_q.ext, 1'b0}, {ax_x_q.ext, 1'b0}}),
    .side_i  (div_side_in),
    .valid_o (div_vld),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  logic [RAD_W-1:0] sq_x_q, sq_y_q;
  seg_in_t          b_item_q;
  logic             b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q   <= div_side.zero_x ? '0 : RAD_W'(quo[0]) * RAD_W'(quo[0]);
      sq_y_q   <= div_side.zero_y ? '0 : RAD_W'(quo[1]) * RAD_W'(quo[1]);
      b_item_q <= div_side.item;
    end
  end

  logic [ROOT_W-1:0] root;
  seg_in_t           c_item;
  logic              c_vld;

  qcf_sqrtpipe #(
    .RT_W(ROOT_W), .BPS(3), .SIDE_W($bits(seg_in_t))
  ) u_sqrt (
    .clk_i, .rst_ni, .en_i,
    .valid_i (b_vld_q),
    .rad_i   (sq_x_q + sq_y_q),
    .side_i  (b_item_q),
    .valid_o (c_vld),
    .root_o  (root),
    .side_o  (c_item)
  );

  logic [SW-1:0] steps_d, steps_q;
  seg_in_t       e_item_q;
  logic          e_vld_q;

  always_comb begin
    logic [MD_W-1:0] md_eff;
    logic [MD_W-1:0] x;
    logic [SCW-1:0]  lhs;
    logic [SW-1:0]   cnt;
    md_eff = (md_i == '0) ? MD_W'(1) : md_i;
    x      = (MD_W'(root) > md_eff) ? md_eff : MD_W'(root);
    lhs    = SCW'(x) * SCW'(MAX_STEPS);
    cnt    = '0;
    for (int j = 1; j <= MAX_STEPS; j++) begin
      if (SCW'(j) * SCW'(md_eff) <= lhs) cnt = cnt + SW'(1);
    end
    steps_d = (!c_item.action || cnt == '0) ? SW'(1) : cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      steps_q  <= steps_d;
      e_item_q <= c_item;
    end
  end

  assign valid_o = e_vld_q;
  assign item_o  = e_item_q;
  assign steps_o = steps_q;

endmodule

// File: sv/qcf_seg.sv
module qcf_seg #(
  parameter int MAX_STEPS = 8,
  parameter int SW        = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qcf_pkg::seg_in_t item_i,
  input  logic [SW-1:0]    steps_i,
  output logic             take_o,
  output logic             valid_o,
  output qcf_pkg::pt_res_t res_o
);
  import qcf_pkg::*;

  localparam int CW = 2 * SW;
  localparam int PW = CW + CRD_W + 1;
  localparam int NW = PW + 2;
  localparam int MW = CW + CRD_W;

  logic          busy_q;
  logic [SW-1:0] k_q, s_q;
  seg_in_t       it_q;
  logic          done, take;

  assign done   = busy_q && (k_q == s_q);
  assign take   = en_i && (!busy_q || done);
  assign take_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (take) begin
      busy_q <= valid_i;
      k_q    <= SW'(1);
    end else if (en_i && busy_q) begin
      k_q    <= k_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s_q  <= steps_i;
      it_q <= item_i;
    end
  end

  logic [SW-1:0] r;
  assign r = s_q - k_q;

  logic [CW-1:0] cr_q, cb_q, cc_q, den1_q;
  coord_t        a1_q [2];
  coord_t        b1_q [2];
  coord_t        c1_q [2];
  pt_side_t      sd1_q;
  logic          v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q   <= CW'(r) * CW'(r);
      cb_q   <= (CW'(k_q) * CW'(r)) << 1;
      cc_q   <= CW'(k_q) * CW'(k_q);
      den1_q <= CW'(s_q) * CW'(s_q);
      a1_q[0] <= it_q.p0_x;
      a1_q[1] <= it_q.p0_y;
      b1_q[0] <= it_q.p1_x;
      b1_q[1] <= it_q.p1_y;
      c1_q[0] <= it_q.action ? it_q.p2_x : it_q.p1_x;
      c1_q[1] <= it_q.action ? it_q.p2_y : it_q.p1_y;
      sd1_q  <= '{first: (k_q == SW'(1)), last: (k_q == s_q), neg_x: 1'b0, neg_y: 1'b0,
                  p0_x: it_q.p0_x, p0_y: it_q.p0_y, fill_a: it_q.fill_a,
                  fill_b: it_q.fill_b, stroke: it_q.stroke};
    end
  end

  logic signed [PW-1:0] pa_q [2];
  logic signed [PW-1:0] pb_q [2];
  logic signed [PW-1:0] pc_q [2];
  logic [CW-1:0]        den2_q;
  pt_side_t             sd2_q;
  logic                 v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        pa_q[l] <= PW'($signed({1'b0, cr_q})) * PW'(a1_q[l]);
        pb_q[l] <= PW'($signed({1'b0, cb_q})) * PW'(b1_q[l]);
        pc_q[l] <= PW'($signed({1'b0, cc_q})) * PW'(c1_q[l]);
      end
      den2_q <= den1_q;
      sd2_q  <= sd1_q;
    end
  end

  logic [1:0][MW-1:0]    mag;
  logic [1:0]            neg;
  pt_side_t              sd_in, sd_out;
  logic [1:0][CRD_W-1:0] quo;
  logic                  dv;

  always_comb begin
    logic signed [NW-1:0] n;
    for (int l = 0; l < 2; l++) begin
      n      = NW'(pa_q[l]) + NW'(pb_q[l]) + NW'(pc_q[l]);
      neg[l] = (n < 0);
      mag[l] = (n < 0) ? MW'(-n) : MW'(n);
    end
    sd_in       = sd2_q;
    sd_in.neg_x = neg[0];
    sd_in.neg_y = neg[1];
  end

  qcf_divpipe #(
    .N_W(MW), .D_W(CW), .Q_W(CRD_W), .BPS(4), .SIDE_W($bits(pt_side_t))
  ) u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v2_q),
    .num_i   (mag),
    .den_i   ({den2_q, den2_q}),
    .side_i  (sd_in),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (sd_out)
  );

  assign valid_o      = dv;
  assign res_o.first  = sd_out.first;
  assign res_o.last   = sd_out.last;
  assign res_o.p0_x   = sd_out.p0_x;
  assign res_o.p0_y   = sd_out.p0_y;
  assign res_o.end_x  = sd_out.neg_x ? -$signed(quo[0]) : $signed(quo[0]);
  assign res_o.end_y  = sd_out.neg_y ? -$signed(quo[1]) : $signed(quo[1]);
  assign res_o.fill_a = sd_out.fill_a;
  assign res_o.fill_b = sd_out.fill_b;
  assign res_o.stroke = sd_out.stroke;

endmodule

// File: sv/quadratic_curve_flattener.sv
// An accepted word passes the step-count pipeline, then the point pipeline and
// the output register before its first output word appears.
// One output word per cycle while out_stall_i is low; a curve holds the input until
// all of its segments (1 to MAX_STEPS) have been issued, and a line has one segment.
// Reset clears all valid bits and loads max_distance with 45875 (0.7 in Q16).
module quadratic_curve_flattener #(
  parameter int MAX_STEPS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qcf_pkg::MD_W-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p0_x_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p0_y_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p1_x_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p1_y_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p2_x_i,
  input  logic signed [qcf_pkg::CRD_W-1:0] p2_y_i,
  input  logic [qcf_pkg::STY_W-1:0]     fill_style_a_i,
  input  logic [qcf_pkg::STY_W-1:0]     fill_style_b_i,
  input  logic [qcf_pkg::STY_W-1:0]     stroke_style_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [qcf_pkg::CRD_W-1:0] start_x_o,
  output logic signed [qcf_pkg::CRD_W-1:0] start_y_o,
  output logic signed [qcf_pkg::CRD_W-1:0] end_x_o,
  output logic signed [qcf_pkg::CRD_W-1:0] end_y_o,
  output logic [qcf_pkg::STY_W-1:0]     out_fill_a_o,
  output logic [qcf_pkg::STY_W-1:0]     out_fill_b_o,
  output logic [qcf_pkg::STY_W-1:0]     out_stroke_o,
  output logic                          last_o
);
  import qcf_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 1);

  logic [MD_W-1:0] md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= MD_RESET;
    end else if (cfg_we_i) begin
      md_q <= cfg_data_i;
    end
  end

  logic    out_vld_q, en, take;
  seg_in_t item_in, f_item;
  logic    f_vld;
  logic [SW-1:0] f_steps;
  pt_res_t res;
  logic    res_vld;

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !take;

  assign item_in = '{action: action_i, p0_x: p0_x_i, p0_y: p0_y_i, p1_x: p1_x_i,
                     p1_y: p1_y_i, p2_x: p2_x_i, p2_y: p2_y_i, fill_a: fill_style_a_i,
                     fill_b: fill_style_b_i, stroke: stroke_style_i};

  qcf_front #(.MAX_STEPS(MAX_STEPS), .SW(SW)) u_front (
    .clk_i, .rst_ni,
    .en_i    (take),
    .valid_i (in_valid_i),
    .item_i  (item_in),
    .md_i    (md_q),
    .valid_o (f_vld),
    .item_o  (f_item),
    .steps_o (f_steps)
  );

  qcf_seg #(.MAX_STEPS(MAX_STEPS), .SW(SW)) u_seg (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (f_vld),
    .item_i  (f_item),
    .steps_i (f_steps),
    .take_o  (take),
    .valid_o (res_vld),
    .res_o   (res)
  );

  coord_t prev_x_q, prev_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_vld) begin
      start_x_o    <= res.first ? res.p0_x : prev_x_q;
      start_y_o    <= res.first ? res.p0_y : prev_y_q;
      end_x_o      <= res.end_x;
      end_y_o      <= res.end_y;
      out_fill_a_o <= res.fill_a;
      out_fill_b_o <= res.fill_b;
      out_stroke_o <= res.stroke;
      last_o       <= res.last;
      prev_x_q     <= res.end_x;
      prev_y_q     <= res.end_y;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// File: sv/qcf_checker.sv
module qcf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [qcf_pkg::CRD_W-1:0] start_x_o,
  input logic signed [qcf_pkg::CRD_W-1:0] start_y_o,
  input logic signed [qcf_pkg::CRD_W-1:0] end_x_o,
  input logic signed [qcf_pkg::CRD_W-1:0] end_y_o,
  input logic                          last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(end_x_o) && $stable(last_o))
    else $error("output word dropped or changed while stalled");

  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && start_x_o == $past(end_x_o) && start_y_o == $past(end_y_o))
    else $error("segment does not continue from previous end point");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output is stalled");

endmodule

bind quadratic_curve_flattener qcf_checker u_qcf_checker (.*);
